>>> rtl/lap3_pkg.sv
// Shared types, constants and register codes of the 3x3 Laplacian stream filter.
// No dependencies; compile before every other file of the block.
package lap3_pkg;

   localparam int LAP3_MAX_WIDTH  = 1024;
   localparam int LAP3_MAX_HEIGHT = 4096;

   localparam int PIXEL_W      = 8;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int SUM_W        = PIXEL_W + 4;

   localparam int WIDTH_RESET  = 1024;
   localparam int HEIGHT_RESET = 1024;

   localparam int OUT_FIFO_DEPTH = 4;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [ROW_W-1:0]   row_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_KERNEL_MODE  = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   typedef enum logic {
      KERNEL_CROSS = 1'b0,
      KERNEL_RING  = 1'b1
   } kernel_type;

   typedef struct packed {
      logic first_row;
      logic last_row;
      logic first_col;
      logic last_col;
   } win_bound_type;

   typedef struct packed {
      pixel_type filtered_value;
      logic      frame_end;
   } rsp_payload_type;

   localparam pixel_type PIXEL_MAX = 8'd255;

endpackage

>>> rtl/lap3_req_if.sv
// Request channel of the Laplacian stream filter: valid/ready with opcode and pixel.
// Depends on lap3_pkg.
interface lap3_req_if;
   import lap3_pkg::*;

   logic      valid;
   logic      ready;
   logic      opcode;
   pixel_type pixel_value;

   modport source (output valid, output opcode, output pixel_value, input ready);
   modport sink (input valid, input opcode, input pixel_value, output ready);

endinterface

>>> rtl/lap3_rsp_if.sv
// Result channel of the Laplacian stream filter: valid/ready with filtered pixel.
// Depends on lap3_pkg.
interface lap3_rsp_if;
   import lap3_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type filtered_value;
   logic      frame_end;

   modport source (output valid, output filtered_value, output frame_end, input ready);
   modport sink (input valid, input filtered_value, input frame_end, output ready);

endinterface

>>> rtl/lap3_line_store.sv
// Two line memories (middle and upper row) with registered reads.
// Same-entry read and write in the same cycle are forwarded. Depends on lap3_pkg.
module lap3_line_store #(
   parameter int MAX_WIDTH = lap3_pkg::LAP3_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  lap3_pkg::pixel_type          wr_pixel,
   input  logic                         wr_tag,
   output lap3_pkg::pixel_type          mid_pixel,
   output logic                         mid_tag,
   output lap3_pkg::pixel_type          up_pixel
);
   import lap3_pkg::*;

   logic [PIXEL_W:0] mid_mem [MAX_WIDTH];
   pixel_type        up_mem [MAX_WIDTH];

   logic [PIXEL_W:0] mid_rd_ff;
   pixel_type        up_rd_ff;
   logic             fwd_ff;
   logic [PIXEL_W:0] fwd_mid_ff;
   pixel_type        fwd_up_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mid_mem[wr_addr] <= {wr_tag, wr_pixel};
         up_mem[wr_addr]  <= mid_pixel;
      end
      if (rd_en) begin
         mid_rd_ff <= mid_mem[rd_addr];
         up_rd_ff  <= up_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_mid_ff <= {wr_tag, wr_pixel};
         fwd_up_ff  <= mid_pixel;
      end
   end

   assign {mid_tag, mid_pixel} = fwd_ff ? fwd_mid_ff : mid_rd_ff;
   assign up_pixel             = fwd_ff ? fwd_up_ff : up_rd_ff;

endmodule

>>> rtl/lap3_window.sv
// 3x3 pixel window fed from the line memories, with edge replication and the
// clamped Laplacian sum. Depends on lap3_pkg.
module lap3_window (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  lap3_pkg::pixel_type    new_pixel,
   input  lap3_pkg::pixel_type    mid_pixel,
   input  logic                   mid_tag,
   input  lap3_pkg::pixel_type    up_pixel,
   input  logic                   kernel_mode,
   input  lap3_pkg::win_bound_type bounds,
   output logic                   centre_tag,
   output lap3_pkg::pixel_type    filtered_value
);
   import lap3_pkg::*;

   pixel_type bot_ff [3];
   pixel_type mid_ff [3];
   pixel_type top_ff [3];
   logic      mid0_tag_ff;
   logic      centre_tag_ff;

   pixel_type  up_row [3];
   pixel_type  dn_row [3];
   logic [1:0] right_idx;
   logic [1:0] left_idx;
   logic [SUM_W-1:0] cross_sum;
   logic [SUM_W-1:0] diag_sum;
   logic [SUM_W-1:0] pos_sum;
   logic [SUM_W-1:0] neg_sum;
   logic [SUM_W-1:0] diff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         bot_ff[0] <= new_pixel;
         bot_ff[1] <= bot_ff[0];
         bot_ff[2] <= bot_ff[1];
         mid_ff[0] <= mid_pixel;
         mid_ff[1] <= mid_ff[0];
         mid_ff[2] <= mid_ff[1];
         top_ff[0] <= up_pixel;
         top_ff[1] <= top_ff[0];
         top_ff[2] <= top_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid0_tag_ff   <= 1'b0;
         centre_tag_ff <= 1'b0;
      end else if (shift_en) begin
         mid0_tag_ff   <= mid_tag;
         centre_tag_ff <= mid0_tag_ff;
      end
   end

   assign centre_tag = centre_tag_ff;

   // column 0 is the right neighbour, column 2 the left one
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         up_row[i] = bounds.first_row ? mid_ff[i] : top_ff[i];
         dn_row[i] = bounds.last_row ? mid_ff[i] : bot_ff[i];
      end
      right_idx = bounds.last_col ? 2'd1 : 2'd0;
      left_idx  = bounds.first_col ? 2'd1 : 2'd2;
   end

   always_comb begin
      cross_sum = SUM_W'(up_row[1]) + SUM_W'(dn_row[1])
                + SUM_W'(mid_ff[right_idx]) + SUM_W'(mid_ff[left_idx]);
      diag_sum  = SUM_W'(up_row[left_idx]) + SUM_W'(up_row[right_idx])
                + SUM_W'(dn_row[left_idx]) + SUM_W'(dn_row[right_idx]);
      if (kernel_mode == KERNEL_RING) begin
         pos_sum = cross_sum + diag_sum;
         neg_sum = SUM_W'(mid_ff[1]) << 3;
      end else begin
         pos_sum = cross_sum;
         neg_sum = SUM_W'(mid_ff[1]) << 2;
      end
      diff = pos_sum - neg_sum;
      if (pos_sum <= neg_sum) begin
         filtered_value = '0;
      end else if (diff > SUM_W'(PIXEL_MAX)) begin
         filtered_value = PIXEL_MAX;
      end else begin
         filtered_value = diff[PIXEL_W-1:0];
      end
   end

endmodule

>>> rtl/lap3_out_fifo.sv
// Small result queue that decouples the filter pipeline from the receiver.
// Drives the result channel. Depends on lap3_pkg and lap3_rsp_if.
module lap3_out_fifo (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          push,
   input  lap3_pkg::rsp_payload_type                     push_data,
   output logic [$clog2(lap3_pkg::OUT_FIFO_DEPTH+1)-1:0] count,
   lap3_rsp_if.source                                    rsp
);
   import lap3_pkg::*;

   localparam int PW = $clog2(OUT_FIFO_DEPTH);
   localparam int CW = $clog2(OUT_FIFO_DEPTH + 1);

   rsp_payload_type slot_ff [OUT_FIFO_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            pop;
   rsp_payload_type head;

   assign pop  = rsp.valid && rsp.ready;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign count              = count_ff;
   assign rsp.valid          = (count_ff != '0);
   assign rsp.filtered_value = head.filtered_value;
   assign rsp.frame_end      = head.frame_end;

endmodule

>>> rtl/laplacian_filter_3x3_stream.sv
// Top level of the streaming 3x3 Laplacian filter: register port, stream counters,
// pipeline control. Depends on lap3_pkg, lap3_req_if, lap3_rsp_if and the lap3 modules.
//
// Usage:
//   req_stream carries pixels in raster order (opcode pixel) and flush ticks
//   (opcode flush) that drain the last rows once a frame has been sent.
//   rsp_stream returns one clamped Laplacian value per pixel in raster order,
//   with frame_end set on the last pixel of each frame.
//   The result for a pixel leaves once the request image_width+1 pushes later
//   is taken; it reaches rsp_stream through the s1 and s2 registers and the result queue.
//   Throughput is one request per cycle while req_stream.ready is high, set by the
//   single read port of each line memory being used once per request; frames may
//   follow without gaps. A flush tick mid-frame or with nothing left to drain is
//   taken and dropped. Writes to image_width or image_height restart the stream; write the
//   registers only while the block is idle. kernel_mode acts at once.
//   Reset clears counters and the result queue; the line memories are not
//   cleared and no sweep is needed. Registers return to width 1024,
//   height 1024, four-neighbour kernel.
//   When the receiver stalls, up to four results queue and req_stream.ready
//   drops once the queue and the pipeline could no longer absorb a request.
module laplacian_filter_3x3_stream #(
   parameter int MAX_WIDTH = lap3_pkg::LAP3_MAX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lap3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lap3_pkg::CSR_DATA_W-1:0]  csr_wdata,
   lap3_req_if.sink                         req_stream,
   lap3_rsp_if.source                       rsp_stream
);
   import lap3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int XW = $clog2(MAX_WIDTH + 2);
   localparam int QW = $clog2(OUT_FIFO_DEPTH + 1);
   localparam int RESET_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam logic [CW-1:0] RESET_LAST_COL = CW'(RESET_W - 1);
   localparam logic [XW-1:0] RESET_WP1      = XW'(RESET_W + 1);
   localparam row_type       RESET_LAST_ROW = ROW_W'(HEIGHT_RESET - 1);

   // configuration
   logic [CW-1:0] last_col_ff, last_col_in;
   logic [XW-1:0] wp1_ff, wp1_in;
   row_type       last_row_ff, last_row_in;
   logic          kernel_mode_ff, kernel_mode_in;

   // stream position
   logic [CW-1:0] in_col_ff, in_col_in;
   row_type       in_row_ff, in_row_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [XW-1:0] gap_ff, gap_in;
   logic [XW-1:0] fill_ff, fill_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   row_type       out_row_ff, out_row_in;

   // pipeline
   logic          s1_push_ff, s1_push_in;
   logic          s1_warm_ff, s1_warm_in;
   logic          s1_tag_ff;
   pixel_type     s1_pixel_ff;
   logic [CW-1:0] s1_addr_ff;
   logic          s2_push_ff, s2_push_in;
   logic          s2_warm_ff, s2_warm_in;

   logic                  [WIDTH_REG_W-1:0]  wr_w_raw;
   logic                  [HEIGHT_REG_W-1:0] wr_h_raw;
   logic                  [WW-1:0]           wr_w;
   logic                  restart;
   logic                  accept;
   logic                  is_flush;
   logic                  at_start;
   logic                  pending;
   logic                  warm;
   logic                  push;
   logic                  push_pixel;
   logic                  out_fire;
   logic                  centre_tag;
   pixel_type             mid_pixel;
   logic                  mid_tag;
   pixel_type             up_pixel;
   pixel_type             filtered_value;
   win_bound_type         bounds;
   rsp_payload_type       out_data;
   logic [QW-1:0]         queue_count;
   logic [QW:0]           committed;

   assign restart = csr_we && ((csr_index == CSR_IMAGE_WIDTH) || (csr_index == CSR_IMAGE_HEIGHT));

   assign committed = (QW + 1)'(queue_count) + (QW + 1)'(s1_push_ff) + (QW + 1)'(s2_push_ff);
   assign req_stream.ready = !reset && (committed < (QW + 1)'(OUT_FIFO_DEPTH));

   assign accept     = req_stream.valid && req_stream.ready;
   assign is_flush   = (req_stream.opcode == OP_FLUSH);
   assign at_start   = (in_col_ff == '0) && (in_row_ff == '0);
   assign pending    = (gap_ff < wp1_ff);
   assign warm       = (fill_ff == wp1_ff);
   assign push_pixel = accept && !is_flush;
   assign push       = push_pixel || (accept && is_flush && at_start && pending);

   assign bounds.first_row = (out_row_ff == '0);
   assign bounds.last_row  = (out_row_ff == last_row_ff);
   assign bounds.first_col = (out_col_ff == '0);
   assign bounds.last_col  = (out_col_ff == last_col_ff);

   assign out_fire = s2_push_ff && s2_warm_ff && centre_tag;
   assign out_data.filtered_value = filtered_value;
   assign out_data.frame_end      = bounds.last_row && bounds.last_col;

   always_comb begin
      wr_w_raw = csr_wdata[WIDTH_REG_W-1:0];
      wr_h_raw = csr_wdata[HEIGHT_REG_W-1:0];
      if (wr_w_raw == '0) begin
         wr_w = WW'(1);
      end else if (32'(wr_w_raw) > MAX_WIDTH) begin
         wr_w = WW'(MAX_WIDTH);
      end else begin
         wr_w = WW'(wr_w_raw);
      end
   end

   always_comb begin
      last_col_in    = last_col_ff;
      wp1_in         = wp1_ff;
      last_row_in    = last_row_ff;
      kernel_mode_in = kernel_mode_ff;
      in_col_in      = in_col_ff;
      in_row_in      = in_row_ff;
      ptr_in         = ptr_ff;
      gap_in         = gap_ff;
      fill_in        = fill_ff;
      out_col_in     = out_col_ff;
      out_row_in     = out_row_ff;

      if (push_pixel) begin
         if (in_col_ff == last_col_ff) begin
            in_col_in = '0;
            in_row_in = (in_row_ff == last_row_ff) ? '0 : in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end

      if (push) begin
         ptr_in = (ptr_ff == last_col_ff) ? '0 : ptr_ff + CW'(1);
         gap_in = push_pixel ? '0 : gap_ff + XW'(1);
         if (!warm) begin
            fill_in = fill_ff + XW'(1);
         end
      end

      if (out_fire) begin
         if (bounds.last_col) begin
            out_col_in = '0;
            out_row_in = bounds.last_row ? '0 : out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end

      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         ptr_in     = '0;
         gap_in     = '1;
         fill_in    = '0;
         out_col_in = '0;
         out_row_in = '0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               last_col_in = CW'(wr_w - WW'(1));
               wp1_in      = XW'(wr_w) + XW'(1);
            end
            CSR_IMAGE_HEIGHT: begin
               if (wr_h_raw == '0) begin
                  last_row_in = '0;
               end else if (32'(wr_h_raw) > LAP3_MAX_HEIGHT) begin
                  last_row_in = ROW_W'(LAP3_MAX_HEIGHT - 1);
               end else begin
                  last_row_in = ROW_W'(wr_h_raw - HEIGHT_REG_W'(1));
               end
            end
            CSR_KERNEL_MODE: begin
               kernel_mode_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_push_in = push;
      s1_warm_in = warm;
      s2_push_in = s1_push_ff;
      s2_warm_in = s1_warm_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff    <= RESET_LAST_COL;
         wp1_ff         <= RESET_WP1;
         last_row_ff    <= RESET_LAST_ROW;
         kernel_mode_ff <= KERNEL_CROSS;
         in_col_ff      <= '0;
         in_row_ff      <= '0;
         ptr_ff         <= '0;
         gap_ff         <= '1;
         fill_ff        <= '0;
         out_col_ff     <= '0;
         out_row_ff     <= '0;
         s1_push_ff     <= 1'b0;
         s1_warm_ff     <= 1'b0;
         s2_push_ff     <= 1'b0;
         s2_warm_ff     <= 1'b0;
      end else begin
         last_col_ff    <= last_col_in;
         wp1_ff         <= wp1_in;
         last_row_ff    <= last_row_in;
         kernel_mode_ff <= kernel_mode_in;
         in_col_ff      <= in_col_in;
         in_row_ff      <= in_row_in;
         ptr_ff         <= ptr_in;
         gap_ff         <= gap_in;
         fill_ff        <= fill_in;
         out_col_ff     <= out_col_in;
         out_row_ff     <= out_row_in;
         s1_push_ff     <= s1_push_in;
         s1_warm_ff     <= s1_warm_in;
         s2_push_ff     <= s2_push_in;
         s2_warm_ff     <= s2_warm_in;
      end
   end

   // flush ticks push a blank pixel
   always_ff @(posedge clock) begin
      if (push) begin
         s1_pixel_ff <= is_flush ? '0 : req_stream.pixel_value;
         s1_tag_ff   <= !is_flush;
         s1_addr_ff  <= ptr_ff;
      end
   end

   lap3_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (push),
      .rd_addr   (ptr_ff),
      .wr_en     (s1_push_ff),
      .wr_addr   (s1_addr_ff),
      .wr_pixel  (s1_pixel_ff),
      .wr_tag    (s1_tag_ff),
      .mid_pixel (mid_pixel),
      .mid_tag   (mid_tag),
      .up_pixel  (up_pixel)
   );

   lap3_window u_window (
      .clock          (clock),
      .reset          (reset),
      .shift_en       (s1_push_ff),
      .new_pixel      (s1_pixel_ff),
      .mid_pixel      (mid_pixel),
      .mid_tag        (mid_tag),
      .up_pixel       (up_pixel),
      .kernel_mode    (kernel_mode_ff),
      .bounds         (bounds),
      .centre_tag     (centre_tag),
      .filtered_value (filtered_value)
   );

   lap3_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_fire),
      .push_data (out_data),
      .count     (queue_count),
      .rsp       (rsp_stream)
   );

endmodule

>>> tb/laplacian_filter_3x3_stream_tb.sv
// Self-checking testbench for laplacian_filter_3x3_stream: a directed table, then random
// frames over many geometries and idle patterns, checked against an in-bench filter model.
// Depends on lap3_pkg, lap3_req_if, lap3_rsp_if and the block's RTL.
module laplacian_filter_3x3_stream_tb;
   import lap3_pkg::*;

   localparam int HIST_DEPTH       = 2 * LAP3_MAX_WIDTH + 3;
   localparam int FRAME_SLOTS      = 4;
   localparam int DRAIN_CYCLES     = 12;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int SEGMENTS         = 16;
   localparam int SEGMENT_REQUESTS = 34;
   localparam int WIDE_SEGMENT     = 6;
   localparam int WIDE_REQUESTS    = 300;
   localparam int DIRECTED_ROWS    = 25;
   localparam int REPORT_LIMIT     = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic                  cfg;
      opcode_type            op;
      pixel_type             pix;
      logic                  typed;
      logic                  want;
      pixel_type             value;
      logic                  fe;
      logic [CSR_DATA_W-1:0] w;
      logic [CSR_DATA_W-1:0] h;
      kernel_type            mode;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lap3_req_if req_bus ();
   lap3_rsp_if rsp_bus ();

   laplacian_filter_3x3_stream u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_stream (req_bus),
      .rsp_stream (rsp_bus)
   );

   // filter model state
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   kernel_type              kernel_reg;
   int unsigned             in_col, in_row, out_col, out_row;
   int unsigned             hist_ptr, push_total, frames_open;
   int unsigned             frame_base [FRAME_SLOTS];
   pixel_type               history [HIST_DEPTH];

   rsp_payload_type expected_pixels [$];
   int              send_idle_pct;
   int              recv_stall_pct;
   int              mismatch_count;
   int              requests_sent;
   int              results_seen;
   int              frames_seen;
   int              settings_written;
   int              cycle_count;

   // 1x1 frames give zero everywhere; a 3x2 checkerboard drives both clamps
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{1'b0, OP_FLUSH, 8'd0,   1'b1, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd255, 1'b1, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b1, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b1, OP_PIXEL, 8'd0,   1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_RING},
      '{1'b0, OP_PIXEL, 8'd255, 1'b1, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b1, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b1, 1'b1, 8'd0, 1'b1, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd0,   1'b1, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd200, 1'b1, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd7,   1'b1, 1'b1, 8'd0, 1'b1, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b1, 1'b1, 8'd0, 1'b1, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b1, 1'b1, 8'd0, 1'b1, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b1, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b1, OP_PIXEL, 8'd0,   1'b0, 1'b0, 8'd0, 1'b0, 13'd3, 13'd2, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd0,   1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd0,   1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_PIXEL, 8'd0,   1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b0, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS},
      '{1'b0, OP_FLUSH, 8'd0,   1'b1, 1'b0, 8'd0, 1'b0, 13'd0, 13'd0, KERNEL_CROSS}
   };

   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > LAP3_MAX_WIDTH) return LAP3_MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned active_height();
      if (height_reg == 0) return 1;
      if (height_reg > LAP3_MAX_HEIGHT) return LAP3_MAX_HEIGHT;
      return height_reg;
   endfunction

   task automatic restart_stream();
      in_col      = 0;
      in_row      = 0;
      out_col     = 0;
      out_row     = 0;
      hist_ptr    = 0;
      push_total  = 0;
      frames_open = 0;
      foreach (frame_base[i]) frame_base[i] = 0;
   endtask

   task automatic reset_filter_model();
      foreach (history[i]) history[i] = '0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      kernel_reg = KERNEL_CROSS;
      restart_stream();
   endtask

   task automatic apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_IMAGE_WIDTH: begin
            width_reg = data[WIDTH_REG_W-1:0];
            restart_stream();
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = data[HEIGHT_REG_W-1:0];
            restart_stream();
         end
         CSR_KERNEL_MODE: kernel_reg = kernel_type'(data[0]);
         default: ;
      endcase
   endtask

   task automatic push_history(input pixel_type v, input int unsigned span);
      history[hist_ptr] = v;
      hist_ptr = (hist_ptr + 1 >= span) ? 0 : hist_ptr + 1;
      push_total++;
   endtask

   function automatic pixel_type history_at(input int unsigned lag, input int unsigned span);
      int unsigned idx;
      if (lag >= span) lag = span - 1;
      idx = hist_ptr + span - 1 - lag;
      if (idx >= span) idx -= span;
      return history[idx];
   endfunction

   task automatic laplacian_step(input opcode_type op, input pixel_type pix,
                                 output bit produced, output rsp_payload_type res);
      int unsigned w, h, span, n;
      int          wi, hi, r, c, dr, dc, rr, cc, off, acc, centre, v;
      bit          at_start;
      produced = 1'b0;
      res      = '0;
      w        = active_width();
      h        = active_height();
      wi       = int'(w);
      hi       = int'(h);
      span     = 2 * w + 3;
      at_start = (in_col == 0 && in_row == 0);
      if (op == OP_PIXEL) begin
         if (at_start && frames_open < FRAME_SLOTS) begin
            frame_base[frames_open] = push_total;
            frames_open++;
         end
         push_history(pix, span);
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
      end else begin
         if (!at_start || frames_open == 0) return;
         push_history('0, span);
      end
      if (frames_open == 0) return;
      r = int'(out_row);
      c = int'(out_col);
      n = out_row * w + out_col;
      if (push_total - frame_base[0] < n + w + 2) return;
      acc    = 0;
      centre = 0;
      for (dr = -1; dr <= 1; dr++) begin
         for (dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            if (rr < 0) rr = 0;
            if (rr > hi - 1) rr = hi - 1;
            cc = c + dc;
            if (cc < 0) cc = 0;
            if (cc > wi - 1) cc = wi - 1;
            off = (rr - r) * wi + (cc - c);
            v = int'(history_at(unsigned'(wi + 1 - off), span));
            if (dr == 0 && dc == 0) centre = v;
            else if (dr == 0 || dc == 0 || kernel_reg == KERNEL_RING) acc += v;
         end
      end
      acc -= centre * ((kernel_reg == KERNEL_RING) ? 8 : 4);
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      res.filtered_value = acc[PIXEL_W-1:0];
      res.frame_end      = 1'b0;
      produced           = 1'b1;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) begin
            out_row       = 0;
            res.frame_end = 1'b1;
            for (int i = 0; i + 1 < FRAME_SLOTS; i++) frame_base[i] = frame_base[i+1];
            frame_base[FRAME_SLOTS-1] = 0;
            frames_open--;
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LIMIT)
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic pixel_type random_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return PIXEL_MAX;
         default: return pixel_type'($urandom_range(255));
      endcase
   endfunction

   task automatic issue_request(input opcode_type op, input pixel_type pix,
                                input bit typed_row = 1'b0, input bit typed_want = 1'b0,
                                input rsp_payload_type typed_res = '0);
      int              gap;
      bit              produced;
      rsp_payload_type predicted;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.pixel_value <= pix;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      requests_sent++;
      laplacian_step(op, pix, produced, predicted);
      if (typed_row) begin
         if (typed_want) expected_pixels.push_back(typed_res);
      end else if (produced) begin
         expected_pixels.push_back(predicted);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_register(idx, data);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                            input kernel_type m);
      logic [CSR_DATA_W-1:0] spare;
      spare = CSR_DATA_W'($urandom);
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_KERNEL_MODE, {spare[CSR_DATA_W-1:1], m});
      csr_write(CSR_SPARE_INDEX, spare);
      csr_we <= 1'b0;
      settings_written++;
   endtask

   // drop valid, wait for every expected result, then let the pipeline empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout: %0d results still outstanding", expected_pixels.size());
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (rsp_bus.frame_end === 1'b1) frames_seen++;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result, value %0d frame_end %0b",
                                      rsp_bus.filtered_value, rsp_bus.frame_end));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_bus.filtered_value !== want.filtered_value)
               report_mismatch($sformatf("result %0d: filtered_value %0d, expected %0d",
                                         results_seen, rsp_bus.filtered_value,
                                         want.filtered_value));
            if (rsp_bus.frame_end !== want.frame_end)
               report_mismatch($sformatf("result %0d: frame_end %0b, expected %0b",
                                         results_seen, rsp_bus.frame_end, want.frame_end));
         end
      end
   end

   initial begin
      int                     directed_count, sent, budget, flushes;
      int unsigned            w, h;
      logic [WIDTH_REG_W-1:0] gw;
      logic [CSR_DATA_W-1:0]  gh;
      logic [1:0]             width_pad;
      kernel_type             gm;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      mismatch_count      = 0;
      requests_sent       = 0;
      results_seen        = 0;
      frames_seen         = 0;
      settings_written    = 0;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_IMAGE_WIDTH;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_PIXEL;
      req_bus.pixel_value <= '0;
      reset_filter_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg) begin
            settle();
            configure(directed_rows[i].w, directed_rows[i].h, directed_rows[i].mode);
         end else begin
            issue_request(directed_rows[i].op, directed_rows[i].pix, directed_rows[i].typed,
                          directed_rows[i].want, {directed_rows[i].value, directed_rows[i].fe});
         end
      end
      directed_count = requests_sent;

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         case (seg)
            1: begin gw = '0; gh = CSR_DATA_W'($urandom_range(1, 5)); end
            2: begin gw = WIDTH_REG_W'($urandom_range(1, 8)); gh = '0; end
            3: begin gw = 11'd2; gh = '1; end
            WIDE_SEGMENT: begin gw = 11'd160; gh = 13'd1; end
            default: begin
               if ($urandom_range(3) == 0) gw = WIDTH_REG_W'($urandom_range(9, 40));
               else gw = WIDTH_REG_W'($urandom_range(1, 8));
               gh = CSR_DATA_W'($urandom_range(1, 6));
            end
         endcase
         width_pad = 2'($urandom_range(3));
         gm        = kernel_type'($urandom_range(1));
         settle();
         configure({width_pad, gw}, gh, gm);
         w      = active_width();
         h      = active_height();
         budget = (seg == WIDE_SEGMENT) ? WIDE_REQUESTS : SEGMENT_REQUESTS;
         sent   = 0;
         while (sent < budget) begin
            for (int p = 0; p < int'(w * h) && sent < budget; p++) begin
               issue_request(OP_PIXEL, random_pixel());
               sent++;
               if (p + 1 < int'(w * h) && $urandom_range(99) < 3) begin
                  issue_request(OP_FLUSH, random_pixel());
                  sent++;
               end
            end
            // otherwise the next frame's pixels drain this one
            if ($urandom_range(99) >= 40) begin
               if ($urandom_range(9) == 0) flushes = $urandom_range(1, w);
               else flushes = w + 1 + ($urandom_range(3) == 0);
               repeat (flushes) issue_request(OP_FLUSH, random_pixel());
               sent += flushes;
            end
         end
      end
      settle();

      $display("Covered %0d requests (%0d directed) over %0d register settings,",
               requests_sent, directed_count, settings_written + 1);
      $display("checking %0d filtered pixels and %0d frame ends.", results_seen, frames_seen);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/lap3_pkg.sv
rtl/lap3_req_if.sv
rtl/lap3_rsp_if.sv
rtl/lap3_line_store.sv
rtl/lap3_window.sv
rtl/lap3_out_fifo.sv
rtl/laplacian_filter_3x3_stream.sv
tb/laplacian_filter_3x3_stream_tb.sv
